@@ rtl/rspd_pkg.sv @@
// Shared types, constants and address helpers for the radial shell peak detector.
// Depends on nothing; used by radial_shell_peak_detect.
`default_nettype none

package rspd_pkg;

  // Grid geometry and value format.
  localparam int GRID_SIDE  = 32;
  localparam int VALUE_BITS = 32;
  localparam int COORD_W    = 5;
  localparam int CELLS      = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int RADIUS_W   = 8;

  typedef logic [COORD_W-1:0]           coord_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;

  // Item operation codes.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_e;

  // Read sequencer: idle, then the three follow-up read steps of a test item.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_RD3
  } state_e;

  // Next coordinate along one axis, with wraparound.
  function automatic coord_t next_coord(input coord_t c);
    next_coord = (c == COORD_W'(GRID_SIDE - 1)) ? '0 : c + COORD_W'(1);
  endfunction

  // Linear address of a grid point; the third coordinate varies fastest.
  function automatic addr_t cell_addr(input coord_t x, input coord_t y, input coord_t z);
    cell_addr = ADDR_W'(x) * ADDR_W'(GRID_SIDE * GRID_SIDE)
              + ADDR_W'(y) * ADDR_W'(GRID_SIDE)
              + ADDR_W'(z);
  endfunction

endpackage

`default_nettype wire

@@ rtl/radial_shell_peak_detect.sv @@
// Radial shell peak detector: three grid memories, a read sequencer and result logic.
// Depends on rspd_pkg for geometry, codes and address helpers.
// Test item: busy while the sequencer steps through ST_RD1, ST_RD2 and ST_RD3, set by the seven
//   lower-shell reads through the two read ports of that memory; no new item is taken until idle.
// Load item: never sets busy, written at the accept edge; result registered through load_q and done_q.
// Results appear for one cycle on done_o and cannot be stalled.
// Reset clears the sequencer, pending-result flags and result strobe only; grid memories hold no reset value.
`default_nettype none

module radial_shell_peak_detect (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start_i,
  output logic                                  busy_o,
  input  wire                                   operation_i,
  input  wire  [rspd_pkg::COORD_W-1:0]          pos_x_i,
  input  wire  [rspd_pkg::COORD_W-1:0]          pos_y_i,
  input  wire  [rspd_pkg::COORD_W-1:0]          pos_z_i,
  input  wire  signed [rspd_pkg::VALUE_BITS-1:0] lower_shell_value_i,
  input  wire  signed [rspd_pkg::VALUE_BITS-1:0] middle_shell_value_i,
  input  wire  signed [rspd_pkg::VALUE_BITS-1:0] upper_shell_value_i,
  input  wire  [rspd_pkg::RADIUS_W-1:0]         radius_index_i,
  output logic                                  done_o,
  output logic                                  hit_o,
  output logic [rspd_pkg::RADIUS_W:0]           peak_radius_o,
  output logic [rspd_pkg::COORD_W-1:0]          peak_x_o,
  output logic [rspd_pkg::COORD_W-1:0]          peak_y_o,
  output logic [rspd_pkg::COORD_W-1:0]          peak_z_o,
  output logic signed [rspd_pkg::VALUE_BITS-1:0] peak_value_o
);

  // Grid memories. Lower has two read ports, middle two, upper one.
  rspd_pkg::value_t lower_mem  [rspd_pkg::CELLS];
  rspd_pkg::value_t middle_mem [rspd_pkg::CELLS];
  rspd_pkg::value_t upper_mem  [rspd_pkg::CELLS];

  rspd_pkg::state_e state_q, state_d;

  logic accept, accept_test, accept_load;

  // Latched coordinates of the test item in flight.
  rspd_pkg::coord_t x_q, y_q, z_q, xp_q, yp_q, zp_q;
  logic [rspd_pkg::RADIUS_W-1:0] radius_q;

  // Input point and its neighbors, used for the reads at the accept edge.
  rspd_pkg::coord_t in_xp, in_yp, in_zp;

  // Read addresses and registered read data.
  rspd_pkg::addr_t lo_addr_a, lo_addr_b, mid_addr_a, mid_addr_b, up_addr;
  rspd_pkg::value_t lo_rd_a_q, lo_rd_b_q, mid_rd_a_q, mid_rd_b_q, up_rd_q;

  // Partial results collected over the read steps.
  rspd_pkg::value_t a_q, ax1_q, ay1_q, az1_q, mshift_q;
  logic flags_q, flags_d;
  logic fin_q, load_q;
  logic final_hit;

  // Output registers.
  logic done_q, hit_q;
  logic [rspd_pkg::RADIUS_W:0] peak_radius_q;
  rspd_pkg::coord_t peak_x_q, peak_y_q, peak_z_q;
  rspd_pkg::value_t peak_value_q;

  // Handshake: an item is taken when the read sequencer is idle.
  assign busy_o      = (state_q != rspd_pkg::ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign accept_test = accept && (operation_i == rspd_pkg::OP_TEST);
  assign accept_load = accept && (operation_i == rspd_pkg::OP_LOAD);

  assign in_xp = rspd_pkg::next_coord(pos_x_i);
  assign in_yp = rspd_pkg::next_coord(pos_y_i);
  assign in_zp = rspd_pkg::next_coord(pos_z_i);

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rspd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and read address selection for each step.
  always_comb begin
    state_d    = state_q;
    lo_addr_a  = rspd_pkg::cell_addr(pos_x_i, pos_y_i, pos_z_i);
    lo_addr_b  = rspd_pkg::cell_addr(in_xp, pos_y_i, pos_z_i);
    mid_addr_a = rspd_pkg::cell_addr(pos_x_i, pos_y_i, pos_z_i);
    mid_addr_b = rspd_pkg::cell_addr(in_xp, in_yp, in_zp);
    up_addr    = rspd_pkg::cell_addr(pos_x_i, pos_y_i, pos_z_i);
    case (state_q)
      rspd_pkg::ST_IDLE: begin
        if (accept_test) begin
          state_d = rspd_pkg::ST_RD1;
        end
      end
      rspd_pkg::ST_RD1: begin
        state_d   = rspd_pkg::ST_RD2;
        lo_addr_a = rspd_pkg::cell_addr(rspd_pkg::next_coord(xp_q), y_q, z_q);
        lo_addr_b = rspd_pkg::cell_addr(x_q, yp_q, z_q);
      end
      rspd_pkg::ST_RD2: begin
        state_d   = rspd_pkg::ST_RD3;
        lo_addr_a = rspd_pkg::cell_addr(x_q, rspd_pkg::next_coord(yp_q), z_q);
        lo_addr_b = rspd_pkg::cell_addr(x_q, y_q, zp_q);
      end
      rspd_pkg::ST_RD3: begin
        state_d   = rspd_pkg::ST_IDLE;
        lo_addr_a = rspd_pkg::cell_addr(x_q, y_q, rspd_pkg::next_coord(zp_q));
        lo_addr_b = rspd_pkg::cell_addr(x_q, y_q, zp_q);
      end
      default: begin
        state_d = rspd_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory writes on a load item, taken at its accept edge.
  always_ff @(posedge clk_i) begin
    if (accept_load) begin
      lower_mem[rspd_pkg::cell_addr(pos_x_i, pos_y_i, pos_z_i)]  <= lower_shell_value_i;
      middle_mem[rspd_pkg::cell_addr(pos_x_i, pos_y_i, pos_z_i)] <= middle_shell_value_i;
      upper_mem[rspd_pkg::cell_addr(pos_x_i, pos_y_i, pos_z_i)]  <= upper_shell_value_i;
    end
  end

  // Synchronous reads; the read data is registered.
  always_ff @(posedge clk_i) begin
    lo_rd_a_q  <= lower_mem[lo_addr_a];
    lo_rd_b_q  <= lower_mem[lo_addr_b];
    mid_rd_a_q <= middle_mem[mid_addr_a];
    mid_rd_b_q <= middle_mem[mid_addr_b];
    up_rd_q    <= upper_mem[up_addr];
  end

  // Latch the test point when it is accepted.
  always_ff @(posedge clk_i) begin
    if (accept_test) begin
      x_q      <= pos_x_i;
      y_q      <= pos_y_i;
      z_q      <= pos_z_i;
      xp_q     <= in_xp;
      yp_q     <= in_yp;
      zp_q     <= in_zp;
      radius_q <= radius_index_i;
    end
  end

  // Fold each step's read data into the running peak condition.
  always_comb begin
    flags_d = flags_q;
    case (state_q)
      rspd_pkg::ST_RD1: begin
        flags_d = (lo_rd_a_q < mid_rd_a_q) && (mid_rd_a_q > up_rd_q)
               && (lo_rd_b_q > lo_rd_a_q);
      end
      rspd_pkg::ST_RD2: begin
        flags_d = flags_q && (lo_rd_a_q < ax1_q) && (lo_rd_b_q > a_q);
      end
      rspd_pkg::ST_RD3: begin
        flags_d = flags_q && (lo_rd_a_q < ay1_q) && (lo_rd_b_q > a_q);
      end
      default: begin
        flags_d = flags_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
    if (state_q == rspd_pkg::ST_RD1) begin
      a_q      <= lo_rd_a_q;
      ax1_q    <= lo_rd_b_q;
      mshift_q <= mid_rd_b_q;
    end
    if (state_q == rspd_pkg::ST_RD2) begin
      ay1_q <= lo_rd_b_q;
    end
    if (state_q == rspd_pkg::ST_RD3) begin
      az1_q <= lo_rd_b_q;
    end
  end

  // Pending-result flags for tests and loads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q  <= 1'b0;
      load_q <= 1'b0;
    end else begin
      fin_q  <= (state_q == rspd_pkg::ST_RD3);
      load_q <= accept_load;
    end
  end

  // Last check: the lower field falls again two steps along the third axis.
  assign final_hit = flags_q && (lo_rd_a_q < az1_q);

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin_q || load_q;
    end
  end

  // Result payload; a load item reports all zeros.
  always_ff @(posedge clk_i) begin
    if (fin_q) begin
      hit_q         <= final_hit;
      peak_radius_q <= final_hit ? ({1'b0, radius_q} + (rspd_pkg::RADIUS_W+1)'(1)) : '0;
      peak_x_q      <= xp_q;
      peak_y_q      <= yp_q;
      peak_z_q      <= zp_q;
      peak_value_q  <= mshift_q;
    end else if (load_q) begin
      hit_q         <= 1'b0;
      peak_radius_q <= '0;
      peak_x_q      <= '0;
      peak_y_q      <= '0;
      peak_z_q      <= '0;
      peak_value_q  <= '0;
    end
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign peak_radius_o = peak_radius_q;
  assign peak_x_o      = peak_x_q;
  assign peak_y_o      = peak_y_q;
  assign peak_z_o      = peak_z_q;
  assign peak_value_o  = peak_value_q;

  // A test result and a load result are never due at the same edge.
  a_no_result_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fin_q && load_q))
    else $error("test and load results due together");

  // An accepted test starts the read steps.
  a_test_starts_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_test |=> (state_q == rspd_pkg::ST_RD1))
    else $error("test item did not start the read sequence");

  // The last read step is followed by its result on done_o, registered through fin_q.
  a_rd3_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rspd_pkg::ST_RD3) |=> ##1 done_o)
    else $error("test result missing after last read step");

  // A miss carries no radius and a hit always does.
  a_radius_follows_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hit_o == (peak_radius_o != '0)))
    else $error("peak radius disagrees with hit flag");

  // A load result never reports a hit.
  a_load_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_q |=> (done_o && !hit_o))
    else $error("load item produced a hit");

endmodule

`default_nettype wire
